>>> hdl/assert_macros.svh
// Assertion helpers for the priority queue block.
// Each macro expects clk and rst in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MPQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define MPQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/mpq_pkg.sv
`timescale 1ns / 1ps

package mpq_pkg;

  // Field widths fixed by the transaction format
  localparam int PRI_W   = 32;
  localparam int ITEM_W  = 16;
  localparam int STAT_W  = 2;

  // Defaults for the top-level parameters
  localparam int DEPTH_DEF     = 64;
  localparam int ITEM_BITS_DEF = 16;

  // Action codes
  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  // Status codes
  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

  // Sequencer controls for the minimum tracker
  typedef struct packed {
    logic load;   // first entry of a scan: take it unconditionally
    logic step;   // later entry: take it only if strictly smaller
  } scan_ctl_t;

endpackage

>>> hdl/mpq_scan.sv
`timescale 1ns / 1ps

// Running-minimum tracker: one signed comparator shared by every step of a scan.
module mpq_scan #(
  parameter int DEPTH     = mpq_pkg::DEPTH_DEF,
  parameter int ITEM_BITS = mpq_pkg::ITEM_BITS_DEF
) (
  input  logic                             clk,
  input  mpq_pkg::scan_ctl_t               ctl,
  input  logic signed [mpq_pkg::PRI_W-1:0] cand_pri,
  input  logic [ITEM_BITS-1:0]             cand_item,
  input  logic [$clog2(DEPTH)-1:0]         cand_idx,
  output logic signed [mpq_pkg::PRI_W-1:0] best_pri,
  output logic [ITEM_BITS-1:0]             best_item,
  output logic [$clog2(DEPTH)-1:0]         best_idx
);

  logic take;

  // Strict less-than keeps the lowest index among equal priorities
  assign take = ctl.load || (ctl.step && (cand_pri < best_pri));

  always_ff @(posedge clk) begin
    if (take) begin
      best_pri  <= cand_pri;
      best_item <= cand_item;
      best_idx  <= cand_idx;
    end
  end

endmodule

>>> hdl/min_priority_queue_linear_scan_unit.sv
`timescale 1ns / 1ps

// Bounded min-priority queue held as an unsorted array of DEPTH slots in one
// memory. Pulse start while busy is low to issue a transaction: action 0
// appends (priority_req, item), action 1 removes the entry with the smallest
// signed Q16.16 priority (lowest slot wins a tie) and moves the last entry
// into its slot. Each transaction yields exactly one result, shown for a
// single cycle while done is high; the receiver cannot stall it, so it must
// sample on that edge. Enqueue, refused enqueue and refused dequeue go
// straight from idle to done. A dequeue over n held entries scans them
// through the single memory read port, which feeds one stored priority
// per cycle into the shared comparator; the read is registered, and the
// result and the move of the last entry follow in the done state.
// No clearing pass is needed after reset.
`include "assert_macros.svh"

module min_priority_queue_linear_scan_unit #(
  parameter int DEPTH     = mpq_pkg::DEPTH_DEF,
  parameter int ITEM_BITS = mpq_pkg::ITEM_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic                               action,
  input  logic signed [mpq_pkg::PRI_W-1:0]   priority_req,
  input  logic [mpq_pkg::ITEM_W-1:0]         item,
  output logic                               busy,
  output logic                               done,
  output logic [mpq_pkg::STAT_W-1:0]         status,
  output logic [mpq_pkg::ITEM_W-1:0]         out_item,
  output logic signed [mpq_pkg::PRI_W-1:0]   out_priority,
  output logic [$clog2(DEPTH+1)-1:0]         count
);

  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WORD_W = mpq_pkg::PRI_W + ITEM_BITS;
  localparam int XW     = (ITEM_BITS > mpq_pkg::ITEM_W) ? ITEM_BITS : mpq_pkg::ITEM_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]                       state;
  logic [CNT_W-1:0]                 fill;
  logic [IDX_W-1:0]                 rd_idx;
  logic                             rd_active;
  logic                             data_vld;
  logic [IDX_W-1:0]                 data_idx;
  logic                             deq_ok;
  logic [mpq_pkg::STAT_W-1:0]       res_status;
  logic [WORD_W-1:0]                last_word;
  logic [WORD_W-1:0]                rd_word;
  logic [WORD_W-1:0]                mem [DEPTH];

  logic [CNT_W-1:0]                 fill_m1;
  logic [IDX_W-1:0]                 last_idx;
  logic                             accept;
  logic                             is_full;
  logic                             enq_ok;
  logic                             empty_ref;
  logic                             mem_we;
  logic [IDX_W-1:0]                 mem_waddr;
  logic [WORD_W-1:0]                mem_wdata;
  logic [XW-1:0]                    item_x;
  logic [ITEM_BITS-1:0]             item_st;
  logic [XW-1:0]                    best_x;
  mpq_pkg::scan_ctl_t               scan_ctl;
  logic signed [mpq_pkg::PRI_W-1:0] best_pri;
  logic [ITEM_BITS-1:0]             best_item;
  logic [IDX_W-1:0]                 best_idx;

  assign fill_m1  = fill - 1'b1;
  assign last_idx = fill_m1[IDX_W-1:0];
  assign accept   = start && (state == S_IDLE);
  assign is_full  = (fill == CNT_W'(DEPTH));
  assign enq_ok   = accept && (action == mpq_pkg::ACT_ENQ) && !is_full;

  // Item kept to ITEM_BITS in storage
  assign item_x  = XW'(item);
  assign item_st = item_x[ITEM_BITS-1:0];

  // Write port: append on enqueue, refill the freed slot at the end of a dequeue
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = fill[IDX_W-1:0];
    mem_wdata = {priority_req, item_st};
    if (enq_ok) begin
      mem_we = 1'b1;
    end else if ((state == S_DONE) && deq_ok) begin
      mem_we    = 1'b1;
      mem_waddr = best_idx;
      mem_wdata = last_word;
    end
  end

  // Slot memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_word <= mem[rd_idx];
  end

  // Tracker controls for the entry arriving from memory
  always_comb begin
    scan_ctl.load = data_vld && (data_idx == '0);
    scan_ctl.step = data_vld && (data_idx != '0);
  end

  mpq_scan #(
    .DEPTH     (DEPTH),
    .ITEM_BITS (ITEM_BITS)
  ) u_scan (
    .clk       (clk),
    .ctl       (scan_ctl),
    .cand_pri  (rd_word[WORD_W-1 -: mpq_pkg::PRI_W]),
    .cand_item (rd_word[ITEM_BITS-1:0]),
    .cand_idx  (data_idx),
    .best_pri  (best_pri),
    .best_item (best_item),
    .best_idx  (best_idx)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      rd_idx    <= '0;
      rd_active <= 1'b0;
      data_vld  <= 1'b0;
      deq_ok    <= 1'b0;
    end else begin
      data_vld <= (state == S_SCAN) && rd_active;
      data_idx <= rd_idx;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (action == mpq_pkg::ACT_ENQ) begin
              deq_ok <= 1'b0;
              state  <= S_DONE;
              if (is_full) begin
                res_status <= mpq_pkg::STATUS_FULL;
              end else begin
                res_status <= mpq_pkg::STATUS_OK;
                fill       <= fill + 1'b1;
              end
            end else if (fill == '0) begin
              deq_ok     <= 1'b0;
              state      <= S_DONE;
              res_status <= mpq_pkg::STATUS_EMPTY;
            end else begin
              res_status <= mpq_pkg::STATUS_OK;
              deq_ok     <= 1'b1;
              rd_idx     <= '0;
              rd_active  <= 1'b1;
              state      <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // Issue one read per cycle up to the last held slot
          if (rd_active) begin
            if (rd_idx == last_idx) begin
              rd_active <= 1'b0;
            end else begin
              rd_idx <= rd_idx + 1'b1;
            end
          end
          // Last entry seen: keep it for the move into the freed slot
          if (data_vld && (data_idx == last_idx)) begin
            last_word <= rd_word;
            state     <= S_DONE;
          end
        end
        S_DONE: begin
          if (deq_ok) begin
            fill <= fill_m1;
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result ports, valid while done is high
  assign best_x       = XW'(best_item);
  assign busy         = (state != S_IDLE);
  assign done         = (state == S_DONE);
  assign status       = res_status;
  assign out_item     = deq_ok ? best_x[mpq_pkg::ITEM_W-1:0] : '0;
  assign out_priority = deq_ok ? best_pri : '0;
  assign count        = deq_ok ? fill_m1 : fill;
  assign empty_ref    = done && (status == mpq_pkg::STATUS_EMPTY);

  // Checks
  `MPQ_ASSERT_IMP(a_fill_bound, 1'b1, fill <= CNT_W'(DEPTH), "fill count above DEPTH")
  `MPQ_ASSERT_NXT(a_enq_grow, enq_ok, fill == CNT_W'($past(fill) + 1'b1), "fill did not grow")
  `MPQ_ASSERT_IMP(a_data_in_scan, data_vld, state == S_SCAN, "read data outside scan")
  `MPQ_ASSERT_IMP(a_empty_count, empty_ref, count == '0, "empty refusal with entries held")

endmodule

>>> tb/min_priority_queue_linear_scan_unit_test.sv
`timescale 1ns / 1ps

module min_priority_queue_linear_scan_unit_test;

  localparam int DEPTH       = mpq_pkg::DEPTH_DEF;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 80;
  localparam int N_DIRECTED  = 26;
  localparam int N_RANDOM    = 100;

  // One result as the block reports it
  typedef struct packed {
    logic [mpq_pkg::STAT_W-1:0] status;
    logic [mpq_pkg::ITEM_W-1:0] item;
    logic [mpq_pkg::PRI_W-1:0]  pri;
    logic [CNT_W-1:0]           count;
  } qresult_t;

  // Directed row: transaction plus, when typed is set, the result to see
  typedef struct packed {
    logic                       act;
    logic [mpq_pkg::PRI_W-1:0]  pri;
    logic [mpq_pkg::ITEM_W-1:0] itm;
    logic                       typed;
    qresult_t                   res;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    // dequeue right after reset is refused
    '{mpq_pkg::ACT_DEQ, 32'h00000000, 16'h0000, 1'b1,
      '{mpq_pkg::STATUS_EMPTY, 16'h0000, 32'h00000000, CNT_W'(0)}},
    // extremes of priority and item
    '{mpq_pkg::ACT_ENQ, 32'h7FFFFFFF, 16'hFFFF, 1'b1,
      '{mpq_pkg::STATUS_OK, 16'h0000, 32'h00000000, CNT_W'(1)}},
    '{mpq_pkg::ACT_ENQ, 32'h80000000, 16'h0000, 1'b1,
      '{mpq_pkg::STATUS_OK, 16'h0000, 32'h00000000, CNT_W'(2)}},
    '{mpq_pkg::ACT_ENQ, 32'h00000000, 16'h1234, 1'b1,
      '{mpq_pkg::STATUS_OK, 16'h0000, 32'h00000000, CNT_W'(3)}},
    '{mpq_pkg::ACT_ENQ, 32'hFFFFFFFF, 16'h5555, 1'b1,
      '{mpq_pkg::STATUS_OK, 16'h0000, 32'h00000000, CNT_W'(4)}},
    // most negative wins; fields of a dequeue are ignored
    '{mpq_pkg::ACT_DEQ, 32'h7FFFFFFF, 16'hFFFF, 1'b1,
      '{mpq_pkg::STATUS_OK, 16'h0000, 32'h80000000, CNT_W'(3)}},
    '{mpq_pkg::ACT_DEQ, 32'h00000000, 16'h0000, 1'b1,
      '{mpq_pkg::STATUS_OK, 16'h5555, 32'hFFFFFFFF, CNT_W'(2)}},
    // tie on zero: lower slot leaves first
    '{mpq_pkg::ACT_ENQ, 32'h00000000, 16'hAAAA, 1'b1,
      '{mpq_pkg::STATUS_OK, 16'h0000, 32'h00000000, CNT_W'(3)}},
    '{mpq_pkg::ACT_DEQ, 32'h00000000, 16'h0000, 1'b1,
      '{mpq_pkg::STATUS_OK, 16'h1234, 32'h00000000, CNT_W'(2)}},
    '{mpq_pkg::ACT_DEQ, 32'h00000000, 16'h0000, 1'b1,
      '{mpq_pkg::STATUS_OK, 16'hAAAA, 32'h00000000, CNT_W'(1)}},
    '{mpq_pkg::ACT_DEQ, 32'h00000000, 16'h0000, 1'b1,
      '{mpq_pkg::STATUS_OK, 16'hFFFF, 32'h7FFFFFFF, CNT_W'(0)}},
    '{mpq_pkg::ACT_DEQ, 32'h7FFFFFFF, 16'hFFFF, 1'b1,
      '{mpq_pkg::STATUS_EMPTY, 16'h0000, 32'h00000000, CNT_W'(0)}},
    // fractional and mixed-sign priorities, checked by prediction
    '{mpq_pkg::ACT_ENQ, 32'h00010000, 16'h0001, 1'b0, '0},
    '{mpq_pkg::ACT_ENQ, 32'hFFFF0000, 16'h0002, 1'b0, '0},
    '{mpq_pkg::ACT_ENQ, 32'h00008000, 16'h0003, 1'b0, '0},
    '{mpq_pkg::ACT_ENQ, 32'h00010000, 16'h0004, 1'b0, '0},
    '{mpq_pkg::ACT_ENQ, 32'h80000001, 16'h0005, 1'b0, '0},
    '{mpq_pkg::ACT_ENQ, 32'hFFFF0000, 16'h0006, 1'b0, '0},
    '{mpq_pkg::ACT_DEQ, 32'h12345678, 16'hBEEF, 1'b0, '0},
    '{mpq_pkg::ACT_DEQ, 32'h00000000, 16'h0000, 1'b0, '0},
    '{mpq_pkg::ACT_DEQ, 32'h00000000, 16'h0000, 1'b0, '0},
    '{mpq_pkg::ACT_DEQ, 32'h00000000, 16'h0000, 1'b0, '0},
    '{mpq_pkg::ACT_ENQ, 32'h7FFFFFFF, 16'h8000, 1'b0, '0},
    '{mpq_pkg::ACT_DEQ, 32'h00000000, 16'h0000, 1'b0, '0},
    '{mpq_pkg::ACT_DEQ, 32'h00000000, 16'h0000, 1'b0, '0},
    '{mpq_pkg::ACT_DEQ, 32'h00000000, 16'h0000, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic action = mpq_pkg::ACT_ENQ;
  logic signed [mpq_pkg::PRI_W-1:0] priority_req = '0;
  logic [mpq_pkg::ITEM_W-1:0] item = '0;
  logic busy;
  logic done;
  logic [mpq_pkg::STAT_W-1:0] status;
  logic [mpq_pkg::ITEM_W-1:0] out_item;
  logic signed [mpq_pkg::PRI_W-1:0] out_priority;
  logic [CNT_W-1:0] count;

  // Shadow of the queue contents
  logic signed [mpq_pkg::PRI_W-1:0] held_pri [DEPTH];
  logic [mpq_pkg::ITEM_W-1:0] held_item [DEPTH];
  int held_count = 0;

  qresult_t pending_results[$];
  qresult_t oldest_result;
  int mismatch_count = 0;
  int cycle_count = 0;

  min_priority_queue_linear_scan_unit #(
    .DEPTH(DEPTH),
    .ITEM_BITS(mpq_pkg::ITEM_BITS_DEF)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .action(action),
    .priority_req(priority_req),
    .item(item),
    .busy(busy),
    .done(done),
    .status(status),
    .out_item(out_item),
    .out_priority(out_priority),
    .count(count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("ERROR at %0t: %s got 0x%0h, wanted 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Apply one transaction to the shadow queue and return what the block should report
  task predict_queue_op(input logic act, input logic signed [mpq_pkg::PRI_W-1:0] pri,
                        input logic [mpq_pkg::ITEM_W-1:0] itm, output qresult_t r);
    int best;
    int k;
    r = '0;
    r.status = mpq_pkg::STATUS_OK;
    if (act == mpq_pkg::ACT_ENQ) begin
      if (held_count >= DEPTH) begin
        r.status = mpq_pkg::STATUS_FULL;
      end else begin
        held_pri[held_count] = pri;
        held_item[held_count] = itm;
        held_count++;
      end
    end else if (held_count == 0) begin
      r.status = mpq_pkg::STATUS_EMPTY;
    end else begin
      // first strictly smaller priority wins
      best = 0;
      for (k = 1; k < held_count; k++)
        if (held_pri[k] < held_pri[best]) best = k;
      r.item = held_item[best];
      r.pri = held_pri[best];
      held_pri[best] = held_pri[held_count - 1];
      held_item[best] = held_item[held_count - 1];
      held_count--;
    end
    r.count = held_count[CNT_W-1:0];
  endtask

  // Issue one transaction, idling first with the given percentage
  task send_item(input logic act, input logic [mpq_pkg::PRI_W-1:0] pri,
                 input logic [mpq_pkg::ITEM_W-1:0] itm,
                 input logic typed, input qresult_t typed_res, input int idle_pct);
    qresult_t r;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      action <= 1'($urandom);
      priority_req <= $urandom;
      item <= 16'($urandom);
      @(posedge clk);
    end
    start <= 1'b1;
    action <= act;
    priority_req <= pri;
    item <= itm;
    @(posedge clk);
    while (busy) @(posedge clk);
    // transaction accepted at this edge
    predict_queue_op(act, pri, itm, r);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  // Hold off until every outstanding result has arrived
  task wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic logic [mpq_pkg::PRI_W-1:0] pick_priority();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFFFFFF;
          1: return 32'h80000000;
          2: return 32'h00000000;
          default: return 32'hFFFFFFFF;
        endcase
      end
      1, 2, 3: return 32'($urandom_range(0, 8)) - 32'd4;  // narrow range forces ties
      default: return $urandom;
    endcase
  endfunction

  // Random walk of the fill level, alternating between filling and draining
  task run_random(input int n, input int idle_pct);
    bit filling;
    logic act;
    filling = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (held_count == DEPTH && $urandom_range(0, 2) == 0) filling = 1'b0;
      else if (held_count == 0 && $urandom_range(0, 2) == 0) filling = 1'b1;
      else if ($urandom_range(0, 99) < 3) filling = !filling;
      if ($urandom_range(0, 99) < 75) act = filling ? mpq_pkg::ACT_ENQ : mpq_pkg::ACT_DEQ;
      else act = filling ? mpq_pkg::ACT_DEQ : mpq_pkg::ACT_ENQ;
      send_item(act, pick_priority(), 16'($urandom), 1'b0, '0, idle_pct);
    end
  endtask

  // Result checker: the block's strobe cannot be held off
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no transaction pending", 32'(status), 32'hFFFFFFFF);
      end else begin
        oldest_result = pending_results.pop_front();
        if (status !== oldest_result.status)
          report_mismatch("status", 32'(status), 32'(oldest_result.status));
        if (out_item !== oldest_result.item)
          report_mismatch("out_item", 32'(out_item), 32'(oldest_result.item));
        if (out_priority !== oldest_result.pri)
          report_mismatch("out_priority", out_priority, oldest_result.pri);
        if (count !== oldest_result.count)
          report_mismatch("count", 32'(count), 32'(oldest_result.count));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int idle_pcts [4];
    idle_pcts = '{0, 73, 0, 28};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows
    for (int i = 0; i < N_DIRECTED; i++)
      send_item(DIRECTED_ROWS[i].act, DIRECTED_ROWS[i].pri, DIRECTED_ROWS[i].itm,
                DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res, 0);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      // fill past full, then empty past zero
      if (p == 0) begin
        for (int i = 0; i < DEPTH + 2; i++)
          send_item(mpq_pkg::ACT_ENQ, pick_priority(), 16'($urandom), 1'b0, '0,
                    idle_pcts[p]);
        for (int i = 0; i < DEPTH + 2; i++)
          send_item(mpq_pkg::ACT_DEQ, $urandom, 16'($urandom), 1'b0, '0, idle_pcts[p]);
      end
      run_random(N_RANDOM, idle_pcts[p]);
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
